// ===== sv/fdd_pkg.sv =====
`timescale 1ns / 1ps
// package: canonical nan constant, nan test and the single-precision add function
package fdd_pkg;

  localparam logic [31:0] CanonNan = 32'h7FC00000;

  function automatic logic is_nan(input logic [31:0] u);
    logic res;
    res = (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
    return res;
  endfunction

  // ieee single add, round to nearest even, subnormals kept
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic        a_inf, b_inf;
    logic [7:0]  eb, es;
    logic [23:0] mb, ms;
    logic [8:0]  ediff;
    logic [26:0] xb, xs;
    logic [27:0] sum;
    logic        sub;
    logic [4:0]  lz;
    logic [27:0] nrm;
    logic [9:0]  e;
    logic [7:0]  ef;
    logic [23:0] mant;
    logic        rnd;
    logic [24:0] mr;
    logic [31:0] res;
    logic        sticky;
    res = 32'd0;
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (is_nan(a) || is_nan(b) || (a_inf && b_inf && (a[31] != b[31]))) begin
      res = CanonNan;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = b;
    end else begin
      if (a[30:0] >= b[30:0]) begin
        big = a; sml = b;
      end else begin
        big = b; sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mb = {big[30:23] != 8'd0, big[22:0]};
      ms = {sml[30:23] != 8'd0, sml[22:0]};
      ediff = {1'b0, eb} - {1'b0, es};
      xb = {mb, 3'b000};
      // align the smaller operand, keep guard, round and sticky
      if (ediff > 9'd26) begin
        xs = {26'd0, ms != 24'd0};
      end else begin
        xs = {ms, 3'b000} >> ediff[4:0];
        sticky = (({ms, 3'b000} & ~(27'h7FFFFFF << ediff[4:0])) != 27'd0);
        xs[0] = xs[0] | sticky;
      end
      sub = big[31] ^ sml[31];
      sum = sub ? ({1'b0, xb} - {1'b0, xs}) : ({1'b0, xb} + {1'b0, xs});
      if (sum == 28'd0) begin
        res = {big[31] & sml[31], 31'd0};
      end else begin
        lz = 5'd0;
        for (int i = 27; i >= 0; i--) begin
          if (sum[i] && lz == 5'd0 && (sum >> (i + 1)) == 28'd0) begin
            lz = 5'(27 - i);
          end
        end
        // exponent after placing the leading one at bit 27
        e = {2'b00, eb} + 10'd1 - {5'd0, lz};
        if ($signed(e) < $signed(10'd1)) begin
          // subnormal result, shift only as far as exponent one allows
          nrm = sum << eb;
          e = 10'd0;
        end else begin
          nrm = sum << lz;
        end
        mant = nrm[27:4];
        rnd = nrm[3] & (nrm[2] | nrm[1] | nrm[0] | nrm[4]);
        mr = {1'b0, mant} + {24'd0, rnd};
        if (e == 10'd0) begin
          ef = mr[23] ? 8'd1 : 8'd0;
          res = {big[31], ef, mr[22:0]};
        end else begin
          if (mr[24]) begin
            e = e + 10'd1;
            mr = mr >> 1;
          end
          if (e >= 10'd255) begin
            res = {big[31], 8'hFF, 23'd0};
          end else begin
            ef = e[7:0];
            res = {big[31], ef, mr[22:0]};
          end
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/fdd_core.sv =====
`timescale 1ns / 1ps
// core: escape tracking, running sum and result register
module fdd_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_i,
  input  logic [31:0] word_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic        out_stall_i,
  output logic        busy_o,
  output logic        out_valid_o,
  output logic [31:0] value_o,
  output logic        is_last_o
);

  logic [31:0] sum_q, sum_d, val_q;
  logic        esc_q, esc_d, vld_q, lst_q, emit;
  logic [31:0] base;
  logic        esc_now;

  assign busy_o = vld_q & out_stall_i;

  always_comb begin
    esc_now = esc_q & ~first_i;
    base    = (first_i | esc_now) ? 32'd0 : sum_q;
    emit    = esc_now | ~fdd_pkg::is_nan(word_i);
    sum_d   = fdd_pkg::fadd(base, word_i);
    esc_d   = ~esc_now & fdd_pkg::is_nan(word_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
      esc_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (req_i) begin
        esc_q <= esc_d;
        if (emit) sum_q <= sum_d;
      end
      if (!busy_o) vld_q <= req_i & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i && emit) begin
      val_q <= sum_d;
      lst_q <= last_i;
    end
  end

  assign out_valid_o = vld_q;
  assign value_o     = val_q;
  assign is_last_o   = lst_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && out_stall_i) |=> (vld_q && $stable(val_q)))
    else $error("result changed under stall");
  a_nan_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i && !esc_q && fdd_pkg::is_nan(word_i) && !out_stall_i) |=> !vld_q)
    else $error("escape word emitted");
  a_esc_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i && !esc_q && !first_i && fdd_pkg::is_nan(word_i)) |=> esc_q)
    else $error("escape not armed");
`endif

endmodule

// ===== sv/float_delta_escape_decoder_top.sv =====
`timescale 1ns / 1ps
// top level of the float delta escape decoder
// usage:
//   input channel: word_i, first_of_blob_i, last_of_blob_i with in_valid_i;
//   a request is taken when in_valid_i is high and in_stall_o is low.
//   output channel: value_o, is_last_o with out_valid_o; a result is taken
//   when out_valid_o is high and out_stall_i is low.
//   a result is registered in the cycle after its request is taken, through one result register.
//   throughput: one word per cycle while in_stall_o is low, set by the combinational float adder on
//   the running-sum loop.
//   a nan word (escape) yields no result unless it follows an escape; the next word restarts the sum.
//   first_of_blob_i clears sum and escape before its word is handled.
//   reset clears the sum to +0.0, the escape flag and the result valid.
//   when the receiver stalls with a result held, in_stall_o rises and
//   no request is taken until the result drains.
module float_delta_escape_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        first_of_blob_i,
  input  logic        last_of_blob_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic        is_last_o
);

  logic busy;

  assign in_stall_o = busy;

  fdd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_valid_i & ~busy),
    .word_i      (word_i),
    .first_i     (first_of_blob_i),
    .last_i      (last_of_blob_i),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .is_last_o   (is_last_o)
  );

endmodule
